### sv/ppat_pkg.sv
package ppat_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 64;

	localparam int unsigned IN_DATA_W  = 80;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		ACT_ANNOUNCE = 2'd0,
		ACT_TICK     = 2'd1,
		ACT_REQUEST  = 2'd2,
		ACT_UNUSED   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NEW  = 2'd1,
		ST_FULL = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	// one table slot as held in the memory
	typedef struct packed {
		logic        valid;
		logic        alive;
		logic [31:0] address;
		logic [15:0] port;
	} slot_t;

endpackage

### sv/peer_presence_aging_table.sv
// peer presence table keyed by ipv4 address and port, aged by mark and sweep
// input stream s_*: one request per item, kind of request in s_tuser
// (announce, aging tick, list request); output stream m_*: one result per request
// the table sits in a single-port-write, single-port-read memory with a registered
// read; announce and tick walk every slot through it, one slot a cycle
// a tick and an announce give their result once the walk ends (an announce ends
// early when the key is found); a list request or an unused code goes straight to
// its result; the next request is taken the cycle after the result is loaded,
// and one request is in flight at a time
// after reset a clearing pass writes every slot empty with
// s_tready low; version, count and flags start at zero
// results leave from an output register; a new request is taken while a result
// waits there, and the block holds its next result until m_tready frees the
// register
module peer_presence_aging_table #(
	parameter int unsigned TABLE_DEPTH = ppat_pkg::TABLE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// peer_address [31:0], peer_port [47:32], held_version [79:48]
	input  logic [ppat_pkg::IN_DATA_W-1:0]     s_tdata,
	// action [1:0]
	input  logic [ppat_pkg::IN_USER_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status [1:0], peer_count [8:2], current_version [40:9], send_list [41], zeros above
	output logic [ppat_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import ppat_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned PAD_W = OUT_DATA_W - 42;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_AGE,
		S_FIN
	} state_t;

	state_t        state_q;
	logic [PW-1:0] rd_ptr_q;
	logic          cmp_vld_s1;
	logic [AW-1:0] cmp_idx_s1;
	logic          free_found_q;
	logic [AW-1:0] free_idx_q;
	logic          removed_q;
	logic [PW-1:0] age_cnt_q;
	logic [31:0]   key_addr_q;
	logic [15:0]   key_port_q;
	logic          set_changed_q;
	logic          bump_pending_q;
	logic [31:0]   list_version_q;
	logic [PW-1:0] listed_total_q;
	status_t       res_status_q;
	logic          res_send_q;
	logic          m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	slot_t         ram_wdata;
	logic [AW-1:0] ram_raddr;
	slot_t         ram_rdata;

	logic          issue;
	logic          scan_end;
	logic          key_match;
	logic [31:0]   next_version;
	logic [6:0]    peer_count;
	action_t       in_action;

	ppat_ram #(
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign in_action = action_t'(s_tuser[1:0]);

	assign issue     = (rd_ptr_q != PW'(TABLE_DEPTH));
	assign scan_end  = !cmp_vld_s1 && !issue;
	assign ram_raddr = rd_ptr_q[AW-1:0];
	assign key_match = ram_rdata.valid && (ram_rdata.address == key_addr_q)
		&& (ram_rdata.port == key_port_q);

	assign next_version = list_version_q + 32'(bump_pending_q);
	assign peer_count   = (32'(listed_total_q) > 32'd127) ? 7'd127 : 7'(listed_total_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cmp_idx_s1;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = rd_ptr_q[AW-1:0];
				ram_wdata = '0;
			end
			S_SCAN: begin
				if (cmp_vld_s1 && key_match) begin
					ram_we          = 1'b1;
					ram_wdata.alive = 1'b1;
				end else if (scan_end && free_found_q) begin
					ram_we    = 1'b1;
					ram_waddr = free_idx_q;
					ram_wdata = '{valid: 1'b1, alive: 1'b1,
						address: key_addr_q, port: key_port_q};
				end
			end
			S_AGE: begin
				// dead entries drop out, survivors lose their mark
				if (cmp_vld_s1 && ram_rdata.valid) begin
					ram_we = 1'b1;
					if (!ram_rdata.alive) begin
						ram_wdata.valid = 1'b0;
					end else begin
						ram_wdata.alive = 1'b0;
					end
				end
			end
			S_IDLE, S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLEAR;
			rd_ptr_q       <= '0;
			cmp_vld_s1     <= 1'b0;
			cmp_idx_s1     <= '0;
			free_found_q   <= 1'b0;
			free_idx_q     <= '0;
			removed_q      <= 1'b0;
			age_cnt_q      <= '0;
			key_addr_q     <= '0;
			key_port_q     <= '0;
			set_changed_q  <= 1'b0;
			bump_pending_q <= 1'b0;
			list_version_q <= '0;
			listed_total_q <= '0;
			res_status_q   <= ST_OK;
			res_send_q     <= 1'b0;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= '0;
		end else begin
			// in S_FIN the output register is reloaded below instead
			if (m_tvalid_q && m_tready && state_q != S_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			if (state_q == S_SCAN || state_q == S_AGE) begin
				if (issue) begin
					rd_ptr_q   <= rd_ptr_q + PW'(1);
					cmp_vld_s1 <= 1'b1;
					cmp_idx_s1 <= rd_ptr_q[AW-1:0];
				end else begin
					cmp_vld_s1 <= 1'b0;
				end
			end
			unique case (state_q)
				S_CLEAR: begin
					if (rd_ptr_q == PW'(TABLE_DEPTH - 1)) begin
						rd_ptr_q <= '0;
						state_q  <= S_IDLE;
					end else begin
						rd_ptr_q <= rd_ptr_q + PW'(1);
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						key_addr_q   <= s_tdata[31:0];
						key_port_q   <= s_tdata[47:32];
						rd_ptr_q     <= '0;
						cmp_vld_s1   <= 1'b0;
						free_found_q <= 1'b0;
						removed_q    <= 1'b0;
						age_cnt_q    <= '0;
						res_status_q <= ST_OK;
						res_send_q   <= 1'b0;
						unique case (in_action)
							ACT_ANNOUNCE: state_q <= S_SCAN;
							ACT_TICK:     state_q <= S_AGE;
							ACT_REQUEST: begin
								// an armed bump lands before the compare
								list_version_q <= next_version;
								bump_pending_q <= 1'b0;
								res_send_q     <= (s_tdata[79:48] != next_version);
								state_q        <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_SCAN: begin
					if (cmp_vld_s1 && key_match) begin
						res_status_q <= ST_OK;
						state_q      <= S_FIN;
					end else begin
						if (cmp_vld_s1 && !ram_rdata.valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= cmp_idx_s1;
						end
						if (scan_end) begin
							if (free_found_q) begin
								res_status_q  <= ST_NEW;
								set_changed_q <= 1'b1;
							end else begin
								res_status_q <= ST_FULL;
							end
							state_q <= S_FIN;
						end
					end
				end
				S_AGE: begin
					if (cmp_vld_s1 && ram_rdata.valid) begin
						if (!ram_rdata.alive) begin
							removed_q <= 1'b1;
						end else begin
							age_cnt_q <= age_cnt_q + PW'(1);
						end
					end
					if (scan_end) begin
						if (set_changed_q || removed_q) begin
							set_changed_q  <= 1'b0;
							bump_pending_q <= 1'b1;
							listed_total_q <= age_cnt_q;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {PAD_W'(0), res_send_q, list_version_q, peer_count,
							res_status_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// one request in flight: the port closes right after a take
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// during aging the write-back slot never collides with the slot being read
	a_age_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && (state_q == S_AGE) |-> ram_waddr != ram_raddr)
		else $error("aging write-back collides with read");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(listed_total_q) <= TABLE_DEPTH)
		else $error("listed count beyond table depth");

	// a bump is armed only at the end of an aging walk
	a_bump_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bump_pending_q) |-> $past(state_q) == S_AGE)
		else $error("version bump armed outside aging");

	// the version moves only by a list request
	a_version_step: assert property (@(posedge clk) disable iff (!arst_n)
		list_version_q != $past(list_version_q) |->
			$past(state_q) == S_IDLE && $past(s_tvalid) && $past(bump_pending_q))
		else $error("version changed without an armed bump");

endmodule

### sv/ppat_ram.sv
module ppat_ram #(
	parameter int unsigned DEPTH = ppat_pkg::TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  ppat_pkg::slot_t          wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output ppat_pkg::slot_t          rdata
);
	import ppat_pkg::*;

	slot_t mem [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
